// ===== design/spcg_pkg.sv =====
// spcg_pkg: shared types, codes and constants of the step pattern click generator
// no dependencies; imported by step_pattern_click_generator
package spcg_pkg;

    localparam int MAX_PATTERN_STEPS_DEF = 256;

    localparam int STEP_W     = 8;
    localparam int LEN_W      = 9;
    localparam int PERIOD_W   = 22;
    localparam int BEATS_W    = 6;
    localparam int SUB_W      = 3;
    localparam int TYPE_W     = 2;
    localparam int MODE_W     = 2;
    localparam int VEL_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int DIV_STEPS  = 9;
    localparam int DIV_CNT_W  = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_SET     = 2'd1,
        MODE_CYCLE   = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    localparam logic [TYPE_W-1:0] TYPE_NORMAL = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_ACCENT = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_MUTE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBDIVISION = 2'd3;

    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 22'd24000;
    localparam logic [BEATS_W-1:0]  BEATS_RST       = 6'd4;
    localparam logic [SUB_W-1:0]    SUB_RST         = 3'd1;
    localparam logic [SUB_W-1:0]    SUB_UNSUPPORTED = 3'd6;

    localparam logic [VEL_W-1:0] VEL_ACCENT = 8'd255;
    localparam logic [VEL_W-1:0] VEL_NORMAL = 8'd153;
    localparam logic [VEL_W-1:0] VEL_MUTE   = 8'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CYCLE,
        ST_DIV_SUB,
        ST_DIV_LEN,
        ST_OUT
    } state_t;

    function automatic logic [VEL_W-1:0] type_velocity(input logic [TYPE_W-1:0] t);
        logic [VEL_W-1:0] v;
        case (t)
            TYPE_ACCENT: v = VEL_ACCENT;
            TYPE_NORMAL: v = VEL_NORMAL;
            default:     v = VEL_MUTE;
        endcase
        return v;
    endfunction

    function automatic logic [TYPE_W-1:0] next_type(input logic [TYPE_W-1:0] t);
        logic [TYPE_W-1:0] n;
        case (t)
            TYPE_NORMAL: n = TYPE_ACCENT;
            TYPE_ACCENT: n = TYPE_MUTE;
            default:     n = TYPE_NORMAL;
        endcase
        return n;
    endfunction

endpackage

// ===== design/step_pattern_click_generator.sv =====
// step pattern click generator: audio sample items and pattern edits in, one result item out
// clicking sample: beat/sub divide, wrap divide, then output load when output is free
// cycle edit: read, write back, output; others: output; one shared 9-step restoring divider
// one item at a time; the next item is taken once the result sits in the output register
// aresetn synchronous active low: config to defaults, playhead and countdown zero, store
// entries read as their reset types through per-entry valid bits, no clearing pass
module step_pattern_click_generator #(
    parameter int MAX_PATTERN_STEPS = spcg_pkg::MAX_PATTERN_STEPS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [spcg_pkg::MODE_W-1:0]          s_mode,
    input  logic [spcg_pkg::STEP_W-1:0]          s_step_index,
    input  logic [spcg_pkg::TYPE_W-1:0]          s_step_type,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_click,
    output logic [spcg_pkg::STEP_W-1:0]          m_click_step,
    output logic [spcg_pkg::STEP_W-1:0]          m_beat_number,
    output logic [spcg_pkg::SUB_W-1:0]           m_sub_position,
    output logic [spcg_pkg::TYPE_W-1:0]          m_click_type,
    output logic [spcg_pkg::VEL_W-1:0]           m_velocity,
    output logic                                 m_downbeat,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spcg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spcg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import spcg_pkg::*;

    localparam int DEPTH = (MAX_PATTERN_STEPS < 256) ? MAX_PATTERN_STEPS : 256;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(DEPTH);

    // config
    logic                running_reg;
    logic [PERIOD_W-1:0] tick_reg;
    logic [BEATS_W-1:0]  beats_reg;
    logic [SUB_W-1:0]    sub_reg;

    // block state
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   playhead_reg, playhead_next;
    logic [PERIOD_W-1:0] count_reg, count_next;

    // pattern store
    logic [TYPE_W-1:0]   mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [TYPE_W-1:0]   mem_wdata;
    logic [STEP_W-1:0]   rd_sel;
    logic [AW-1:0]       rd_addr;
    logic [TYPE_W-1:0]   rd_mem_reg;
    logic                rd_valid_reg;
    logic                rd_zero_reg;
    logic                rd_inside_reg;
    logic [TYPE_W-1:0]   rd_type;
    logic [STEP_W-1:0]   edit_idx_reg, edit_idx_next;

    // shared divider
    logic [LEN_W-1:0]     div_rem_reg, div_rem_next;
    logic [LEN_W-1:0]     div_quo_reg, div_quo_next;
    logic [LEN_W-1:0]     div_den_reg, div_den_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [LEN_W-1:0]     div_trial;
    logic                 div_ge;
    logic [LEN_W-1:0]     div_rem_step;
    logic [LEN_W-1:0]     div_quo_step;
    logic                 div_last;

    // pending result
    logic                res_click_reg, res_click_next;
    logic [STEP_W-1:0]   res_step_reg, res_step_next;
    logic [STEP_W-1:0]   res_beat_reg, res_beat_next;
    logic [SUB_W-1:0]    res_sub_reg, res_sub_next;
    logic [TYPE_W-1:0]   res_type_reg, res_type_next;
    logic [VEL_W-1:0]    res_vel_reg, res_vel_next;
    logic                res_down_reg, res_down_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic                m_load;

    // derived config
    logic [SUB_W-1:0]    eff_sub;
    logic [BEATS_W-1:0]  eff_beats;
    logic [LEN_W-1:0]    len_raw;
    logic [LEN_W-1:0]    pat_len;
    logic [PERIOD_W-1:0] eff_period;
    logic                s_fire;

    assign eff_sub    = (sub_reg == '0 || sub_reg == SUB_UNSUPPORTED) ? SUB_W'(1) : sub_reg;
    assign eff_beats  = (beats_reg == '0) ? BEATS_W'(1) : beats_reg;
    assign len_raw    = LEN_W'(eff_beats) * LEN_W'(eff_sub);
    assign pat_len    = (len_raw > CAP) ? CAP : len_raw;
    assign eff_period = (tick_reg == '0) ? PERIOD_W'(1) : tick_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

    assign div_trial    = {div_rem_reg[LEN_W-2:0], div_quo_reg[LEN_W-1]};
    assign div_ge       = (div_trial >= div_den_reg);
    assign div_rem_step = div_ge ? (div_trial - div_den_reg) : div_trial;
    assign div_quo_step = {div_quo_reg[LEN_W-2:0], div_ge};
    assign div_last     = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    assign rd_sel  = (state_reg == ST_IDLE && s_mode == MODE_CYCLE) ? s_step_index
                                                                    : playhead_reg;
    assign rd_addr = rd_sel[AW-1:0];

    always_comb begin
        if (!rd_inside_reg) begin
            rd_type = TYPE_MUTE;
        end else if (rd_valid_reg) begin
            rd_type = (rd_mem_reg > TYPE_MUTE) ? TYPE_MUTE : rd_mem_reg;
        end else begin
            rd_type = rd_zero_reg ? TYPE_ACCENT : TYPE_NORMAL;
        end
    end

    // config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            tick_reg    <= TICK_PERIOD_RST;
            beats_reg   <= BEATS_RST;
            sub_reg     <= SUB_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RUNNING:     running_reg <= cfg_data[0];
                CFG_TICK_PERIOD: tick_reg    <= cfg_data[PERIOD_W-1:0];
                CFG_BEATS:       beats_reg   <= cfg_data[BEATS_W-1:0];
                CFG_SUBDIVISION: sub_reg     <= cfg_data[SUB_W-1:0];
                default: ;
            endcase
        end
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_mem_reg    <= mem[rd_addr];
        rd_valid_reg  <= valid_reg[rd_addr];
        rd_zero_reg   <= (rd_sel == '0);
        rd_inside_reg <= ({1'b0, rd_sel} < CAP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            playhead_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            playhead_reg <= playhead_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_den_reg   <= div_den_next;
        edit_idx_reg  <= edit_idx_next;
        res_click_reg <= res_click_next;
        res_step_reg  <= res_step_next;
        res_beat_reg  <= res_beat_next;
        res_sub_reg   <= res_sub_next;
        res_type_reg  <= res_type_next;
        res_vel_reg   <= res_vel_next;
        res_down_reg  <= res_down_next;
        if (m_load) begin
            m_click        <= res_click_reg;
            m_click_step   <= res_step_reg;
            m_beat_number  <= res_beat_reg;
            m_sub_position <= res_sub_reg;
            m_click_type   <= res_type_reg;
            m_velocity     <= res_vel_reg;
            m_downbeat     <= res_down_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        playhead_next  = playhead_reg;
        count_next     = count_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        edit_idx_next  = edit_idx_reg;
        res_click_next = res_click_reg;
        res_step_next  = res_step_reg;
        res_beat_next  = res_beat_reg;
        res_sub_next   = res_sub_reg;
        res_type_next  = res_type_reg;
        res_vel_next   = res_vel_reg;
        res_down_next  = res_down_reg;
        mem_we         = 1'b0;
        mem_waddr      = s_step_index[AW-1:0];
        mem_wdata      = (s_step_type > TYPE_MUTE) ? TYPE_MUTE : s_step_type;
        m_load         = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    res_click_next = 1'b0;
                    res_step_next  = '0;
                    res_beat_next  = '0;
                    res_sub_next   = '0;
                    res_type_next  = '0;
                    res_vel_next   = '0;
                    res_down_next  = 1'b0;
                    edit_idx_next  = s_step_index;
                    state_next     = ST_OUT;
                    case (s_mode)
                        MODE_SET: begin
                            res_step_next = s_step_index;
                            mem_we        = ({1'b0, s_step_index} < CAP);
                        end
                        MODE_CYCLE: begin
                            res_step_next = s_step_index;
                            state_next    = ST_CYCLE;
                        end
                        MODE_RESTART: begin
                            playhead_next = '0;
                            count_next    = eff_period;
                        end
                        default: begin
                            if (running_reg) begin
                                if (count_reg == '0) begin
                                    div_rem_next = '0;
                                    div_quo_next = LEN_W'(playhead_reg);
                                    div_den_next = LEN_W'(eff_sub);
                                    div_cnt_next = '0;
                                    state_next   = ST_DIV_SUB;
                                end else begin
                                    count_next = count_reg - PERIOD_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            ST_CYCLE: begin
                mem_waddr  = edit_idx_reg[AW-1:0];
                mem_wdata  = next_type(rd_type);
                mem_we     = ({1'b0, edit_idx_reg} < pat_len);
                state_next = ST_OUT;
            end
            ST_DIV_SUB: begin
                div_rem_next = div_rem_step;
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_last) begin
                    res_beat_next = div_quo_step[STEP_W-1:0];
                    res_sub_next  = div_rem_step[SUB_W-1:0];
                    div_rem_next  = '0;
                    div_quo_next  = LEN_W'(playhead_reg) + LEN_W'(1);
                    div_den_next  = pat_len;
                    div_cnt_next  = '0;
                    state_next    = ST_DIV_LEN;
                end
            end
            ST_DIV_LEN: begin
                div_rem_next = div_rem_step;
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_last) begin
                    res_click_next = 1'b1;
                    res_step_next  = playhead_reg;
                    res_type_next  = rd_type;
                    res_vel_next   = type_velocity(rd_type);
                    res_down_next  = (playhead_reg == '0);
                    playhead_next  = div_rem_step[STEP_W-1:0];
                    count_next     = eff_period - PERIOD_W'(1);
                    div_cnt_next   = '0;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_load       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_downbeat_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_click |-> (m_downbeat == (m_click_step == '0)))
        else $error("downbeat does not match click step");

    a_quiet_no_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_click |-> (m_velocity == '0 && !m_downbeat))
        else $error("non-click item carries velocity or downbeat");

    a_sub_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_LEN) && div_last |-> (res_sub_reg < eff_sub))
        else $error("sub position not below subdivision");

    a_playhead_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, playhead_reg} < CAP))
        else $error("playhead beyond store");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_SUB) && div_last |=> (state_reg == ST_DIV_LEN && div_cnt_reg == '0))
        else $error("divider sequencing broken");
`endif

endmodule
